/* design/todc_pkg.sv */
// Shared types and constants for the time-of-day clock with two alarms.
package todc_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MIN_W     = 6;
  localparam int unsigned SEC_W     = 6;
  localparam int unsigned CODE_W    = 2;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 6;

  // Largest legal value of each time field.
  localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
  localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
  localparam logic [SEC_W-1:0]  SEC_MAX  = 6'd59;

  // Request command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // Alarm codes reported with every result.
  localparam logic [CODE_W-1:0] CODE_NONE  = 2'd0;
  localparam logic [CODE_W-1:0] CODE_OPEN  = 2'd1;
  localparam logic [CODE_W-1:0] CODE_CLOSE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_HOUR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_MINUTE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_SECOND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_HOUR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_MINUTE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_SECOND = 3'd5;

  // Input request payload.
  typedef struct packed {
    logic              cmd;
    logic [HOUR_W-1:0] set_hour;
    logic [MIN_W-1:0]  set_minute;
    logic [SEC_W-1:0]  set_second;
  } in_req_t;

  // Result payload.
  typedef struct packed {
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [CODE_W-1:0]  alarm_code;
    logic [TOTAL_W-1:0] elapsed_seconds;
  } out_rsp_t;

  // One alarm time.
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } alarm_time_t;

  // Both alarm settings, passed from the register file to the time unit.
  typedef struct packed {
    alarm_time_t open_alarm;
    alarm_time_t close_alarm;
  } alarm_cfg_t;

endpackage

/* design/todc_alarm_regs.sv */
// Configuration register file holding the open and close alarm times.
module todc_alarm_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [todc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [todc_pkg::CFG_DAT_W-1:0]    cfg_data,
  output todc_pkg::alarm_cfg_t              alarm_cfg
);

  todc_pkg::alarm_cfg_t alarm_cfg_r;
  todc_pkg::alarm_cfg_t alarm_cfg_nxt;

  // The register file can always take a write.
  assign cfg_ready = 1'b1;

  // Decode the register index; unknown indexes leave everything unchanged.
  always_comb begin
    alarm_cfg_nxt = alarm_cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        todc_pkg::REG_OPEN_HOUR:
          alarm_cfg_nxt.open_alarm.hour = cfg_data[todc_pkg::HOUR_W-1:0];
        todc_pkg::REG_OPEN_MINUTE:
          alarm_cfg_nxt.open_alarm.minute = cfg_data[todc_pkg::MIN_W-1:0];
        todc_pkg::REG_OPEN_SECOND:
          alarm_cfg_nxt.open_alarm.second = cfg_data[todc_pkg::SEC_W-1:0];
        todc_pkg::REG_CLOSE_HOUR:
          alarm_cfg_nxt.close_alarm.hour = cfg_data[todc_pkg::HOUR_W-1:0];
        todc_pkg::REG_CLOSE_MINUTE:
          alarm_cfg_nxt.close_alarm.minute = cfg_data[todc_pkg::MIN_W-1:0];
        todc_pkg::REG_CLOSE_SECOND:
          alarm_cfg_nxt.close_alarm.second = cfg_data[todc_pkg::SEC_W-1:0];
        default: begin
          alarm_cfg_nxt = alarm_cfg_r;
        end
      endcase
    end
  end

  // Alarm registers clear to midnight at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_cfg_r <= '0;
    end else begin
      alarm_cfg_r <= alarm_cfg_nxt;
    end
  end

  assign alarm_cfg = alarm_cfg_r;

endmodule

/* design/todc_time.sv */
// Time-of-day counters, elapsed-second count and alarm compare.
module todc_time (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 commit,
  input  todc_pkg::in_req_t    req,
  input  todc_pkg::alarm_cfg_t alarm_cfg,
  output todc_pkg::out_rsp_t   rsp_nxt
);

  logic [todc_pkg::HOUR_W-1:0]  hour_r,  hour_nxt;
  logic [todc_pkg::MIN_W-1:0]   min_r,   min_nxt;
  logic [todc_pkg::SEC_W-1:0]   sec_r,   sec_nxt;
  logic [todc_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic                         open_hit;
  logic                         close_hit;

  // Next time: either load the saturated set values or advance one second.
  always_comb begin
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    total_nxt = total_r;
    if (req.cmd == todc_pkg::CMD_SET) begin
      hour_nxt = (req.set_hour > todc_pkg::HOUR_MAX) ? todc_pkg::HOUR_MAX : req.set_hour;
      min_nxt  = (req.set_minute > todc_pkg::MIN_MAX) ? todc_pkg::MIN_MAX : req.set_minute;
      sec_nxt  = (req.set_second > todc_pkg::SEC_MAX) ? todc_pkg::SEC_MAX : req.set_second;
    end else begin
      total_nxt = total_r + 1'b1;
      if (sec_r == todc_pkg::SEC_MAX) begin
        sec_nxt = '0;
        if (min_r == todc_pkg::MIN_MAX) begin
          min_nxt = '0;
          hour_nxt = (hour_r == todc_pkg::HOUR_MAX) ? '0 : hour_r + 1'b1;
        end else begin
          min_nxt = min_r + 1'b1;
        end
      end else begin
        sec_nxt = sec_r + 1'b1;
      end
    end
  end

  // Alarm compare against the new time; the open alarm has priority.
  assign open_hit  = (alarm_cfg.open_alarm.hour == hour_nxt) &&
                     (alarm_cfg.open_alarm.minute == min_nxt) &&
                     (alarm_cfg.open_alarm.second == sec_nxt);
  assign close_hit = (alarm_cfg.close_alarm.hour == hour_nxt) &&
                     (alarm_cfg.close_alarm.minute == min_nxt) &&
                     (alarm_cfg.close_alarm.second == sec_nxt);

  // Assemble the result for the request being committed.
  always_comb begin
    rsp_nxt.hour            = hour_nxt;
    rsp_nxt.minute          = min_nxt;
    rsp_nxt.second          = sec_nxt;
    rsp_nxt.elapsed_seconds = total_nxt;
    if (open_hit) begin
      rsp_nxt.alarm_code = todc_pkg::CODE_OPEN;
    end else if (close_hit) begin
      rsp_nxt.alarm_code = todc_pkg::CODE_CLOSE;
    end else begin
      rsp_nxt.alarm_code = todc_pkg::CODE_NONE;
    end
  end

  // Time state updates only when a request moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r  <= '0;
      min_r   <= '0;
      sec_r   <= '0;
      total_r <= '0;
    end else if (commit) begin
      hour_r  <= hour_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      total_r <= total_nxt;
    end
  end

  // The time of day always stays within a legal day.
  a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (hour_r <= todc_pkg::HOUR_MAX) && (min_r <= todc_pkg::MIN_MAX) &&
    (sec_r <= todc_pkg::SEC_MAX))
    else $error("time of day out of range");

  // A committed tick adds exactly one to the elapsed count.
  a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (req.cmd == todc_pkg::CMD_TICK) |=> total_r == $past(total_r) + 1'b1)
    else $error("tick did not advance elapsed count");

  // A committed set command leaves the elapsed count alone.
  a_set_keeps_total: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (req.cmd == todc_pkg::CMD_SET) |=> $stable(total_r))
    else $error("set command changed elapsed count");

  // Without a commit the time state does not move.
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(hour_r) && $stable(min_r) && $stable(sec_r) && $stable(total_r))
    else $error("time state changed without a commit");

endmodule

/* design/time_of_day_clock_with_two_alarms_core.sv */
// Top level of the 24-hour time-of-day clock with open and close alarms.
//
// Usage: each request on the in_ channel is either a one-second tick or a
// set-time command. Every request produces exactly one result on the out_
// channel carrying the time, the elapsed-second count and the alarm code.
// The user must write alarm times through the cfg_ channel only while the
// block is idle; the block does not enforce it. cfg_ready is always high.
// A request is captured in an input register, and the time update and alarm
// compare run combinationally from that register to the result register.
// A request passes through the input register and then the result register
// before out_valid shows its result; while out_stall is low, one request per
// cycle is sustained. The time counters update once per request in that stage.
// When the receiver stalls, the held result stays in the result register
// and the input register still takes one more request; in_stall rises only
// when both registers are full.
// Synchronous reset clears the time, the elapsed count, the alarm times and
// both valid flags.
module time_of_day_clock_with_two_alarms_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  todc_pkg::in_req_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output todc_pkg::out_rsp_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [todc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [todc_pkg::CFG_DAT_W-1:0] cfg_data
);

  logic                 req_valid_r;
  todc_pkg::in_req_t    req_r;
  logic                 out_valid_r;
  todc_pkg::out_rsp_t   out_rsp_r;
  todc_pkg::out_rsp_t   rsp_nxt;
  todc_pkg::alarm_cfg_t alarm_cfg;
  logic                 req_adv;
  logic                 in_take;

  // Alarm configuration registers.
  todc_alarm_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .alarm_cfg (alarm_cfg)
  );

  // Time keeping and alarm compare.
  todc_time u_time (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (req_adv),
    .req       (req_r),
    .alarm_cfg (alarm_cfg),
    .rsp_nxt   (rsp_nxt)
  );

  // The held request moves on whenever the result register is free or drains.
  assign req_adv  = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !req_adv;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_take) begin
      req_valid_r <= 1'b1;
    end else if (req_adv) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_adv) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_rsp_r;

  // A valid result never carries the unused alarm code.
  a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rsp_r.alarm_code == todc_pkg::CODE_NONE) ||
                    (out_rsp_r.alarm_code == todc_pkg::CODE_OPEN) ||
                    (out_rsp_r.alarm_code == todc_pkg::CODE_CLOSE))
    else $error("illegal alarm code on result");

  // A request only waits in the input register while a result is stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> req_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  // A request that advances shows up as a valid result next cycle.
  a_adv_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    req_adv |=> out_valid_r)
    else $error("advanced request produced no result");

endmodule
